// ===== design/lgrid_pkg.sv =====
// ----------------------------------------------------------------------------
// lgrid_pkg
// Shared constants, codes and helpers for the occupancy grid ray update block.
// ----------------------------------------------------------------------------
package lgrid_pkg;

	localparam int GRID_MAX     = 128;
	localparam int GRID_AW      = 7;
	localparam int CELL_W       = 5;
	localparam int ROW_W        = GRID_MAX * CELL_W;
	localparam int SINE_ENTRIES = 256;
	localparam int TURN         = 23040;
	// angle / 90 by reciprocal: exact for every angle below one turn
	localparam int IDX_MUL      = 46604;
	localparam int IDX_SHIFT    = 22;
	localparam int QUOT_W       = 17;
	localparam int MIN_RANGE_MM = 50;
	localparam int OCC_STEP     = 6;
	localparam int FREE_STEP    = 4;
	localparam int OCC_LIMIT    = 10;
	localparam int FREE_LIMIT   = -10;

	localparam logic [1:0] OP_RAY   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [2:0] ST_APPLIED = 3'd0;
	localparam logic [2:0] ST_RANGE   = 3'd1;
	localparam logic [2:0] ST_OUTSIDE = 3'd2;
	localparam logic [2:0] ST_CLEARED = 3'd3;
	localparam logic [2:0] ST_READ    = 3'd4;

	localparam logic [1:0] CLS_UNKNOWN  = 2'd0;
	localparam logic [1:0] CLS_FREE     = 2'd1;
	localparam logic [1:0] CLS_OCCUPIED = 2'd2;

	localparam logic [1:0] REG_HALF_MAP = 2'd0;
	localparam logic [1:0] REG_CELL_MM  = 2'd1;
	localparam logic [1:0] REG_CELLS    = 2'd2;
	localparam logic [1:0] REG_OFFSET   = 2'd3;

	typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];

	function automatic logic [31:0] quarter_sine(input logic [31:0] q);
		logic [31:0] x2;
		logic [31:0] p;
		x2 = (q * q) >> 14;
		p  = 32'd77;
		p  = 32'd1306 - ((x2 * p) >> 14);
		p  = 32'd10583 - ((x2 * p) >> 14);
		p  = 32'd25736 - ((x2 * p) >> 14);
		return (q * p) >> 14;
	endfunction

	function automatic sine_tab_t build_sine();
		sine_tab_t   tab;
		logic [31:0] t;
		logic [31:0] f;
		logic [31:0] s;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			t = 32'(i * (65536 / SINE_ENTRIES));
			f = t & 32'h3FFF;
			if (t[14]) s = quarter_sine(32'd16384 - f);
			else       s = quarter_sine(f);
			tab[i] = t[15] ? -16'(s) : 16'(s);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

	// saturating counter update
	function automatic logic signed [CELL_W-1:0] sat_add(input logic signed [CELL_W-1:0] v,
			input logic up);
		logic signed [CELL_W:0] r;
		r = up ? ({v[CELL_W-1], v} + (CELL_W+1)'(OCC_STEP))
		       : ({v[CELL_W-1], v} - (CELL_W+1)'(FREE_STEP));
		if (r > (CELL_W+1)'(OCC_LIMIT)) r = (CELL_W+1)'(OCC_LIMIT);
		if (r < (CELL_W+1)'(FREE_LIMIT)) r = (CELL_W+1)'(FREE_LIMIT);
		return r[CELL_W-1:0];
	endfunction

endpackage

// ===== design/lidar_occupancy_grid_ray_update.sv =====
// ----------------------------------------------------------------------------
// lidar_occupancy_grid_ray_update
// Occupancy grid of saturating log-odds counters, updated along lidar rays.
//
// channel   direction  handshake                     payload
// item      in         start & !busy                 opcode range_mm bearing
//                                                    cell_col cell_row
// result    out        done, one cycle, no stall     status cell_value cell_class
//                                                    cells_touched
// config    in         cfg_we                        cfg_idx cfg_wdata
//
// Range reject and clear: result in the cycle after the item. Read: the row is
// registered, then S_CRD sets the result. Ray: angle index, trig and two
// 17-bit serial divides (an off-grid end reports then), then per grid cell
// walked a row read, modify, write back; at most 65 cells at a 128-cell side.
// The grid is stored one row per memory word; per-row valid bits are cleared
// at reset and by a clear item. busy stays high until the result.
// ----------------------------------------------------------------------------
module lidar_occupancy_grid_ray_update
	import lgrid_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               opcode,
	input  logic [15:0]              range_mm,
	input  logic [14:0]              bearing,
	input  logic [6:0]               cell_col,
	input  logic [6:0]               cell_row,
	output logic                     done,
	output logic [2:0]               status,
	output logic signed [CELL_W-1:0] cell_value,
	output logic [1:0]               cell_class,
	output logic [8:0]               cells_touched,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_idx,
	input  logic [15:0]              cfg_wdata
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_IDX  = 4'd1;
	localparam logic [3:0] S_TRIG = 4'd2;
	localparam logic [3:0] S_NUM  = 4'd3;
	localparam logic [3:0] S_DIVX = 4'd4;
	localparam logic [3:0] S_DIVY = 4'd5;
	localparam logic [3:0] S_RD   = 4'd6;
	localparam logic [3:0] S_WR   = 4'd7;
	localparam logic [3:0] S_CRD  = 4'd8;

	logic [15:0] half_q, cellmm_q;
	logic [7:0]  cells_q;
	logic [14:0] offset_q;

	logic [3:0]  state_q;
	logic [15:0] dist_q;
	logic [14:0] angle_q;
	logic [7:0]  idx_q;
	logic signed [32:0] prodc_s2, prods_s2;
	logic [QUOT_W-1:0] nysh_q, xquo_q;
	logic [GRID_AW-1:0] x0_q, y0_q, x1_q, y1_q, col_q, row_q;
	logic signed [10:0] dx_q, dy_q, err_q;
	logic sx_q, sy_q;
	logic [8:0] touched_q;
	logic [GRID_MAX-1:0] row_vld_q;

	logic done_q;
	logic [2:0] status_q;
	logic signed [CELL_W-1:0] value_q;
	logic [1:0] class_q;
	logic [8:0] touched_out_q;

	logic [ROW_W-1:0] mem [GRID_MAX];
	logic [ROW_W-1:0] rd_data_q;
	logic [GRID_AW-1:0] rd_addr;
	logic mem_we;
	logic [ROW_W-1:0] row_cur, row_new;

	logic [15:0] sum;
	logic [14:0] angle_n;
	logic [30:0] idx_prod;
	logic [7:0]  n_cells;
	logic [6:0]  centre;
	logic range_rej;
	logic signed [31:0] nx, ny;
	logic div_start, div_done;
	logic [QUOT_W-1:0] div_dvd, div_quo;
	logic [15:0] divisor;
	logic [GRID_AW-1:0] wx1, wy1;
	logic signed [10:0] w_dx, w_dy;
	logic signed [11:0] e2;
	logic step_x, step_y, at_end;
	logic signed [10:0] err_nxt;
	logic signed [CELL_W-1:0] old_v, new_v, rd_v;
	logic [1:0] rd_cls;
	logic accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		n_cells   = (cells_q > 8'd128) ? 8'd128 : cells_q;
		centre    = n_cells[7:1];
		range_rej = (range_mm <= 16'(MIN_RANGE_MM)) || (range_mm >= half_q);
		sum       = {1'b0, bearing} + {1'b0, offset_q};
		if (sum >= 16'(2 * TURN))  angle_n = 15'(sum - 16'(2 * TURN));
		else if (sum >= 16'(TURN)) angle_n = 15'(sum - 16'(TURN));
		else                       angle_n = sum[14:0];
		idx_prod = 31'(angle_q) * 31'(IDX_MUL);
		nx = 32'({2'b00, half_q, 14'd0}) + prodc_s2[31:0];
		ny = 32'({2'b00, half_q, 14'd0}) - prods_s2[31:0];
		divisor = (cellmm_q == '0) ? 16'd1 : cellmm_q;
		div_start = 1'b0;
		div_dvd   = nx[30:14];
		if (state_q == S_NUM && !nx[31] && !ny[31]) div_start = 1'b1;
		if (state_q == S_DIVX && div_done) begin
			div_start = 1'b1;
			div_dvd   = nysh_q;
		end
		// walk setup from the two quotients
		wx1  = xquo_q[GRID_AW-1:0];
		wy1  = div_quo[GRID_AW-1:0];
		w_dx = (wx1 > centre) ? 11'(wx1 - centre) : 11'(centre - wx1);
		w_dy = (wy1 > centre) ? -11'(wy1 - centre) : -11'(centre - wy1);
		// one Bresenham step
		e2      = {err_q[10], err_q} <<< 1;
		step_x  = e2 >= 12'(dy_q);
		step_y  = e2 <= 12'(dx_q);
		err_nxt = err_q + (step_x ? dy_q : 11'sd0) + (step_y ? dx_q : 11'sd0);
		at_end  = (x0_q == x1_q) && (y0_q == y1_q);
		// row read-modify-write; an invalid row reads as zero
		row_cur = row_vld_q[y0_q] ? rd_data_q : '0;
		old_v   = row_cur[int'(x0_q) * CELL_W +: CELL_W];
		new_v   = sat_add(old_v, at_end);
		row_new = row_cur;
		row_new[int'(x0_q) * CELL_W +: CELL_W] = new_v;
		mem_we  = (state_q == S_WR);
		rd_addr = (state_q == S_IDLE) ? cell_row : y0_q;
		// cell read
		rd_v = '0;
		if (row_vld_q[row_q] && (8'(col_q) < n_cells) && (8'(row_q) < n_cells))
			rd_v = rd_data_q[int'(col_q) * CELL_W +: CELL_W];
		if (rd_v >= CELL_W'(OCC_LIMIT))       rd_cls = CLS_OCCUPIED;
		else if (rd_v <= CELL_W'(FREE_LIMIT)) rd_cls = CLS_FREE;
		else                                  rd_cls = CLS_UNKNOWN;
	end

	lgrid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (mem_we) mem[y0_q] <= row_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= 16'd2500;
			cellmm_q <= 16'd50;
			cells_q  <= 8'd100;
			offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HALF_MAP: half_q   <= cfg_wdata;
				REG_CELL_MM:  cellmm_q <= cfg_wdata;
				REG_CELLS:    cells_q  <= cfg_wdata[7:0];
				REG_OFFSET:   offset_q <= cfg_wdata[14:0];
				default:      ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				dist_q  <= range_mm;
				angle_q <= angle_n;
				col_q   <= cell_col;
				row_q   <= cell_row;
			end
			S_IDX:  idx_q <= idx_prod[IDX_SHIFT+7:IDX_SHIFT];
			S_TRIG: begin
				prodc_s2 <= $signed({1'b0, dist_q}) * SINE_TAB[idx_q + 8'd64];
				prods_s2 <= $signed({1'b0, dist_q}) * SINE_TAB[idx_q];
			end
			S_NUM:  nysh_q <= ny[30:14];
			S_DIVX: if (div_done) xquo_q <= div_quo;
			S_DIVY: begin
				x0_q  <= centre;
				y0_q  <= centre;
				x1_q  <= wx1;
				y1_q  <= wy1;
				dx_q  <= w_dx;
				dy_q  <= w_dy;
				sx_q  <= centre < wx1;
				sy_q  <= centre < wy1;
				err_q <= w_dx + w_dy;
			end
			S_WR: begin
				if (step_x) x0_q <= sx_q ? x0_q + 7'd1 : x0_q - 7'd1;
				if (step_y) y0_q <= sy_q ? y0_q + 7'd1 : y0_q - 7'd1;
				err_q <= err_nxt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			row_vld_q     <= '0;
			touched_q     <= '0;
			done_q        <= 1'b0;
			status_q      <= ST_APPLIED;
			value_q       <= '0;
			class_q       <= CLS_UNKNOWN;
			touched_out_q <= '0;
		end else begin
			done_q        <= 1'b0;
			value_q       <= '0;
			class_q       <= CLS_UNKNOWN;
			touched_out_q <= '0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_RAY: begin
								if (range_rej) begin
									done_q   <= 1'b1;
									status_q <= ST_RANGE;
								end else begin
									state_q <= S_IDX;
								end
							end
							OP_CLEAR: begin
								row_vld_q <= '0;
								done_q    <= 1'b1;
								status_q  <= ST_CLEARED;
							end
							OP_READ: state_q <= S_CRD;
							default: ;
						endcase
					end
				end
				S_IDX:  state_q <= S_TRIG;
				S_TRIG: state_q <= S_NUM;
				S_NUM: begin
					if (nx[31] || ny[31]) begin
						done_q   <= 1'b1;
						status_q <= ST_OUTSIDE;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_DIVX;
					end
				end
				S_DIVX: if (div_done) state_q <= S_DIVY;
				S_DIVY: begin
					if (div_done) begin
						if (xquo_q >= QUOT_W'(n_cells) || div_quo >= QUOT_W'(n_cells)) begin
							done_q   <= 1'b1;
							status_q <= ST_OUTSIDE;
							state_q  <= S_IDLE;
						end else begin
							touched_q <= '0;
							state_q   <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_WR;
				S_WR: begin
					row_vld_q[y0_q] <= 1'b1;
					touched_q       <= touched_q + 9'd1;
					if (at_end) begin
						done_q        <= 1'b1;
						status_q      <= ST_APPLIED;
						touched_out_q <= touched_q + 9'd1;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_CRD: begin
					done_q   <= 1'b1;
					status_q <= ST_READ;
					value_q  <= rd_v;
					class_q  <= rd_cls;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign cell_value    = value_q;
	assign cell_class    = class_q;
	assign cells_touched = touched_out_q;

	a_touch_only_ray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_APPLIED) |-> (cells_touched == '0))
		else $error("cells touched on a non-ray result");

	a_ray_touches: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_APPLIED) |-> (cells_touched != '0))
		else $error("applied ray walked no cell");

	a_value_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_READ) |-> (cell_value == '0 && cell_class == CLS_UNKNOWN))
		else $error("cell value on a non-read result");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> ($past(state_q) == S_RD))
		else $error("row written without a read");

endmodule

// ===== design/lgrid_div.sv =====
// ----------------------------------------------------------------------------
// lgrid_div
// Restoring divider, one quotient bit per cycle, for the end cell index.
// ----------------------------------------------------------------------------
module lgrid_div
	import lgrid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [QUOT_W-1:0] dividend,
	input  logic [15:0]       divisor,
	output logic              done,
	output logic [QUOT_W-1:0] quotient
);

	logic [QUOT_W-1:0] quo_q;
	logic [QUOT_W-1:0] rem_q;
	logic [4:0]        cnt_q;
	logic              done_q;
	logic [QUOT_W-1:0] rem_shift;
	logic [QUOT_W-1:0] rem_nxt;
	logic              ge;

	always_comb begin
		rem_shift = {rem_q[QUOT_W-2:0], quo_q[QUOT_W-1]};
		ge        = rem_shift >= {1'b0, divisor};
		rem_nxt   = ge ? rem_shift - {1'b0, divisor} : rem_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= 5'(QUOT_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 5'd1;
			done_q <= (cnt_q == 5'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[QUOT_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
